// ===== rtl/sbd_pkg.sv =====
// Shared types, codes and helpers for the system bus decoder.
`default_nettype none

package sbd_pkg;

    // Request commands
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_LOAD  = 2'd2;

    // Device codes on address bits 59:56
    localparam logic [3:0] DEV_RAM  = 4'h0;
    localparam logic [3:0] DEV_PORT = 4'h1;
    localparam logic [3:0] DEV_ROM  = 4'hF;

    // Fault codes
    localparam logic [1:0] FAULT_OK       = 2'd0;
    localparam logic [1:0] FAULT_CARD     = 2'd1;
    localparam logic [1:0] FAULT_UNMAPPED = 2'd2;

    localparam logic [15:0] VALID_CARDS  = 16'h8003;
    localparam logic [63:0] FILL_PATTERN = 64'hCCCC_CCCC_CCCC_CCCC;

    // Offset bits carried through the queue: covers the largest RAM or ROM
    localparam int OFS_BITS = 24;

    // Queue depth between front and back
    localparam int Q_DEPTH = 2;

    // Operation codes decided by the front
    typedef logic [2:0] op_t;
    localparam op_t OP_NONE    = 3'd0;
    localparam op_t OP_FILL    = 3'd1;
    localparam op_t OP_RAM_RD  = 3'd2;
    localparam op_t OP_RAM_WR  = 3'd3;
    localparam op_t OP_ROM_RD  = 3'd4;
    localparam op_t OP_ROM_LD  = 3'd5;
    localparam op_t OP_PORT_RD = 3'd6;
    localparam op_t OP_PORT_WR = 3'd7;

    typedef struct packed {
        op_t                 op;
        logic [1:0]          fault;
        logic [1:0]          size_code;
        logic [OFS_BITS-1:0] ofs;
        logic [63:0]         data;   // store data, or port input for a port read
    } item_t;

    function automatic logic [63:0] size_mask(input logic [1:0] size_code);
        logic [63:0] m;
        unique case (size_code)
            2'd0:    m = 64'h0000_0000_0000_00FF;
            2'd1:    m = 64'h0000_0000_0000_FFFF;
            2'd2:    m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] lane_mask(input logic [1:0] size_code);
        logic [7:0] m;
        unique case (size_code)
            2'd0:    m = 8'h01;
            2'd1:    m = 8'h03;
            2'd2:    m = 8'h0F;
            default: m = 8'hFF;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sbd_if.sv =====
// Request and response channel interfaces of the system bus decoder.
`default_nettype none

interface sbd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [63:0] address;
    logic [1:0]  size_code;
    logic [63:0] write_data;
    logic [63:0] port_input_value;

    modport source (
        output valid, command, address, size_code, write_data, port_input_value,
        input  ready
    );
    modport sink (
        input  valid, command, address, size_code, write_data, port_input_value,
        output ready
    );
endinterface

interface sbd_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] read_data;
    logic [1:0]  fault;

    modport source (
        output valid, read_data, fault,
        input  ready
    );
    modport sink (
        input  valid, read_data, fault,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/sbd_front.sv =====
// Front end: accepts bus requests and decodes card, device and operation.
`default_nettype none

module sbd_front (
    sbd_req_if.sink        req,
    input  logic           q_ready,
    output logic           push,
    output sbd_pkg::item_t push_item
);
    import sbd_pkg::*;

    logic [3:0] card;
    logic [3:0] dev;
    logic       card_ok;
    logic       is_read;
    op_t        op;
    logic [1:0] fault;

    assign card    = req.address[63:60];
    assign dev     = req.address[59:56];
    assign card_ok = VALID_CARDS[card];
    assign is_read = (req.command == CMD_READ);

    always_comb
    begin
        op    = OP_NONE;
        fault = FAULT_OK;
        unique case (req.command) inside
            CMD_LOAD:
            begin
                op = OP_ROM_LD;
            end
            CMD_READ, CMD_WRITE:
            begin
                if (!card_ok)
                begin
                    fault = FAULT_CARD;
                    op    = is_read ? OP_FILL : OP_NONE;
                end
                else if (dev == DEV_RAM)
                begin
                    op = is_read ? OP_RAM_RD : OP_RAM_WR;
                end
                else if (dev == DEV_PORT)
                begin
                    op = is_read ? OP_PORT_RD : OP_PORT_WR;
                end
                else if (dev == DEV_ROM && is_read)
                begin
                    op = OP_ROM_RD;
                end
                else
                begin
                    // unmapped device, or a store to ROM
                    fault = FAULT_UNMAPPED;
                    op    = is_read ? OP_FILL : OP_NONE;
                end
            end
            default:
            begin
                op = OP_NONE;
            end
        endcase
    end

    assign req.ready = q_ready;
    assign push      = req.valid && q_ready;

    always_comb
    begin
        push_item.op        = op;
        push_item.fault     = fault;
        push_item.size_code = req.size_code;
        push_item.ofs       = req.address[OFS_BITS-1:0];
        push_item.data      = (op == OP_PORT_RD) ? req.port_input_value : req.write_data;
    end

endmodule

`default_nettype wire

// ===== rtl/sbd_queue.sv =====
// Two-entry queue of decoded requests between front and back.
`default_nettype none

module sbd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sbd_pkg::item_t push_item,
    output logic           ready,
    output logic           head_valid,
    output sbd_pkg::item_t head_item,
    input  logic           pop
);
    import sbd_pkg::*;

    localparam int PTR_BITS = $clog2(Q_DEPTH);
    localparam int CNT_BITS = $clog2(Q_DEPTH + 1);

    item_t               entry_reg [Q_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;

    assign ready      = (count_reg != CNT_BITS'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sbd_back.sv =====
// Back end: RAM and ROM byte-lane banks, port register and response register.
`default_nettype none

module sbd_back #(
    parameter int RAM_ADDR_BITS = 16,
    parameter int ROM_ADDR_BITS = 12
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  sbd_pkg::item_t head_item,
    output logic           pop,
    sbd_rsp_if.source      rsp
);
    import sbd_pkg::*;

    localparam int LANES        = 8;
    localparam int RAM_ROW_BITS = RAM_ADDR_BITS - 3;
    localparam int RAM_ROWS     = 1 << RAM_ROW_BITS;
    localparam int ROM_ROW_BITS = ROM_ADDR_BITS - 3;
    localparam int ROM_ROWS     = 1 << ROM_ROW_BITS;

    // issue stage: memory data is registered at the pop and arrives in the cycle after it
    logic        s1_valid_reg;
    logic        s1_valid_next;
    op_t         s1_op_reg;
    logic [1:0]  s1_fault_reg;
    logic [2:0]  s1_lo_reg;
    logic [1:0]  s1_size_reg;
    logic [63:0] s1_value_reg;
    logic        s1_move;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [63:0] out_data_reg;
    logic [1:0]  out_fault_reg;

    logic [63:0] port_reg;
    logic [63:0] port_next;

    logic [2:0]  lo;
    logic [5:0]  shift;
    logic [7:0]  lanes_en;
    logic [63:0] smask;
    logic [63:0] port_lanes;
    logic [63:0] port_src;
    logic [63:0] issue_value;

    logic [RAM_ROW_BITS-1:0] ram_base;
    logic [ROM_ROW_BITS-1:0] rom_base;
    logic [63:0]             ram_word;
    logic [63:0]             rom_word;
    logic [63:0]             mem_word;
    logic [127:0]            mem_pair;
    logic [63:0]             mem_rot;
    logic [63:0]             s1_result;

    assign s1_move = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign pop     = head_valid && (!s1_valid_reg || s1_move);

    assign lo       = head_item.ofs[2:0];
    assign shift    = {lo, 3'b000};
    assign lanes_en = lane_mask(head_item.size_code);
    assign smask    = size_mask(head_item.size_code);
    assign ram_base = head_item.ofs[RAM_ADDR_BITS-1:3];
    assign rom_base = head_item.ofs[ROM_ADDR_BITS-1:3];

    // Byte i of an access sits in lane (lo + i) mod 8; lanes below lo take the next row.
    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        localparam logic [2:0] LANE = 3'(l);

        logic [2:0]              idx;
        logic                    wrap;
        logic [RAM_ROW_BITS-1:0] ram_row;
        logic [ROM_ROW_BITS-1:0] rom_row;
        logic [7:0]              wr_byte;
        logic [7:0]              ram_mem [RAM_ROWS];
        logic [7:0]              rom_mem [ROM_ROWS];
        logic [7:0]              ram_q_reg;
        logic [7:0]              rom_q_reg;

        assign idx     = LANE - lo;
        assign wrap    = (LANE < lo);
        assign ram_row = ram_base + RAM_ROW_BITS'(wrap);
        assign rom_row = rom_base + ROM_ROW_BITS'(wrap);
        assign wr_byte = 8'(head_item.data >> {idx, 3'b000});

        always_ff @(posedge clk)
        begin
            if (pop && head_item.op == OP_RAM_WR && lanes_en[idx])
            begin
                ram_mem[ram_row] <= wr_byte;
            end
            if (pop && head_item.op == OP_RAM_RD)
            begin
                ram_q_reg <= ram_mem[ram_row];
            end
        end

        always_ff @(posedge clk)
        begin
            if (pop && head_item.op == OP_ROM_LD && idx == 3'd0)
            begin
                rom_mem[rom_row] <= wr_byte;
            end
            if (pop && head_item.op == OP_ROM_RD)
            begin
                rom_q_reg <= rom_mem[rom_row];
            end
        end

        assign ram_word[8*l +: 8] = ram_q_reg;
        assign rom_word[8*l +: 8] = rom_q_reg;
    end

    // General-purpose port
    assign port_lanes = smask << shift;
    assign port_src   = head_item.ofs[3] ? port_reg : head_item.data;

    always_comb
    begin
        port_next = port_reg;
        if (pop && head_item.op == OP_PORT_WR && head_item.ofs[3])
        begin
            port_next = (port_reg & ~port_lanes) | ((head_item.data << shift) & port_lanes);
        end
    end

    always_comb
    begin
        case (head_item.op)
            OP_PORT_RD: issue_value = (port_src >> shift) & smask;
            OP_FILL:    issue_value = FILL_PATTERN & smask;
            default:    issue_value = '0;
        endcase
    end

    // Rotate the lane word so byte 0 of the access lands in the low byte.
    assign mem_word  = (s1_op_reg == OP_ROM_RD) ? rom_word : ram_word;
    assign mem_pair  = {mem_word, mem_word} >> {s1_lo_reg, 3'b000};
    assign mem_rot   = mem_pair[63:0];
    assign s1_result = (s1_op_reg == OP_RAM_RD || s1_op_reg == OP_ROM_RD)
                       ? (mem_rot & size_mask(s1_size_reg)) : s1_value_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (pop)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            port_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            port_reg      <= port_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_op_reg    <= head_item.op;
            s1_fault_reg <= head_item.fault;
            s1_lo_reg    <= lo;
            s1_size_reg  <= head_item.size_code;
            s1_value_reg <= issue_value;
        end
        if (s1_move)
        begin
            out_data_reg  <= s1_result;
            out_fault_reg <= s1_fault_reg;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;
    assign rsp.fault     = out_fault_reg;

endmodule

`default_nettype wire

// ===== rtl/system_bus_decoder_with_ram_rom.sv =====
// Top level of the system bus decoder with RAM, ROM and general-purpose port.
//
//   channel  modport  dir  moves
//   -------  -------  ---  ---------------------------------------------------
//   req      sink     in   command, address, size_code, write_data, port input
//   rsp      source   out  read_data, fault
//
// One request per cycle is accepted while req.ready is high, one response per request, in order.
// When the path is clear a request passes the queue, the issue stage with its registered
// byte-lane RAM/ROM read, and the response register.
// Reset clears the queue, the pipeline and the port output register; RAM and ROM
// contents are kept as they are.
// A stalled rsp fills the response register, the issue stage and the two-entry
// queue before req.ready drops.
`default_nettype none

module system_bus_decoder_with_ram_rom #(
    parameter int RAM_ADDR_BITS = 16,
    parameter int ROM_ADDR_BITS = 12
) (
    input  logic      clk,
    input  logic      rst_n,
    sbd_req_if.sink   req,
    sbd_rsp_if.source rsp
);
    import sbd_pkg::*;

    logic  push;
    item_t push_item;
    logic  q_ready;
    logic  head_valid;
    item_t head_item;
    logic  pop;

    sbd_front u_front (
        .req       (req),
        .q_ready   (q_ready),
        .push      (push),
        .push_item (push_item)
    );

    sbd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .ready      (q_ready),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop)
    );

    sbd_back #(
        .RAM_ADDR_BITS (RAM_ADDR_BITS),
        .ROM_ADDR_BITS (ROM_ADDR_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

// ===== tb/sv/system_bus_decoder_with_ram_rom_tb.sv =====
// Self-checking testbench for the system bus decoder with RAM, ROM and port.
`timescale 1ns / 100ps

module system_bus_decoder_with_ram_rom_tb;
    import sbd_pkg::*;

    localparam int RAM_ADDR_BITS = 16;
    localparam int ROM_ADDR_BITS = 12;
    localparam int RAM_BYTES     = 1 << RAM_ADDR_BITS;
    localparam int ROM_BYTES     = 1 << ROM_ADDR_BITS;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 830;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] SIZE_1B    = 2'd0;
    localparam logic [1:0] SIZE_2B    = 2'd1;
    localparam logic [1:0] SIZE_4B    = 2'd2;
    localparam logic [1:0] SIZE_8B    = 2'd3;

    typedef struct {
        logic [63:0] read_data;
        logic [1:0]  fault;
    } bus_response_t;

    logic clk;
    logic rst_n;

    sbd_req_if req_ch ();
    sbd_rsp_if rsp_ch ();

    system_bus_decoder_with_ram_rom #(
        .RAM_ADDR_BITS(RAM_ADDR_BITS),
        .ROM_ADDR_BITS(ROM_ADDR_BITS)
    ) DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    // Shadow copy of the memories, the port register and which bytes hold data
    logic [7:0]  ram_image [RAM_BYTES];
    bit          ram_filled [RAM_BYTES];
    logic [7:0]  rom_image [ROM_BYTES];
    bit          rom_filled [ROM_BYTES];
    logic [63:0] port_out_image;

    bus_response_t pending_responses[$];
    int            mismatch_count;
    bit            no_gaps;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic bit is_valid_card(input logic [3:0] card);
        return VALID_CARDS[card];
    endfunction

    // Apply one request to the shadow state and return the response it must produce
    function automatic bus_response_t decode_access(
        input logic [1:0]  cmd,
        input logic [63:0] addr,
        input logic [1:0]  sz,
        input logic [63:0] wdata,
        input logic [63:0] pin
    );
        bus_response_t                resp;
        logic [3:0]                   card;
        logic [3:0]                   dev;
        logic [63:0]                  width_mask;
        logic [63:0]                  lanes;
        logic [63:0]                  src;
        logic [RAM_ADDR_BITS-1:0]     ram_idx;
        logic [ROM_ADDR_BITS-1:0]     rom_idx;
        int                           nbytes;
        int                           shift;
        int                           i;
        card = addr[63:60];
        dev = addr[59:56];
        nbytes = 1 << sz;
        width_mask = {64{1'b1}} >> (64 - 8 * nbytes);
        shift = 8 * addr[2:0];
        resp.read_data = '0;
        resp.fault = FAULT_OK;
        if (cmd == CMD_LOAD)
        begin
            rom_idx = addr[ROM_ADDR_BITS-1:0];
            rom_image[rom_idx] = wdata[7:0];
            rom_filled[rom_idx] = 1'b1;
        end
        else if (cmd == CMD_READ || cmd == CMD_WRITE)
        begin
            if (!is_valid_card(card))
            begin
                resp.fault = FAULT_CARD;
                if (cmd == CMD_READ)
                    resp.read_data = FILL_PATTERN & width_mask;
            end
            else if (dev == DEV_RAM)
            begin
                for (i = 0; i < nbytes; i++)
                begin
                    ram_idx = addr[RAM_ADDR_BITS-1:0] + i[RAM_ADDR_BITS-1:0];
                    if (cmd == CMD_READ)
                        resp.read_data[8*i +: 8] = ram_image[ram_idx];
                    else
                    begin
                        ram_image[ram_idx] = wdata[8*i +: 8];
                        ram_filled[ram_idx] = 1'b1;
                    end
                end
            end
            else if (dev == DEV_PORT)
            begin
                if (cmd == CMD_READ)
                begin
                    src = addr[3] ? port_out_image : pin;
                    resp.read_data = (src >> shift) & width_mask;
                end
                else if (addr[3])
                begin
                    // lanes pushed past bit 63 fall off the top
                    lanes = width_mask << shift;
                    port_out_image = (port_out_image & ~lanes) | ((wdata << shift) & lanes);
                end
            end
            else if (dev == DEV_ROM && cmd == CMD_READ)
            begin
                for (i = 0; i < nbytes; i++)
                begin
                    rom_idx = addr[ROM_ADDR_BITS-1:0] + i[ROM_ADDR_BITS-1:0];
                    resp.read_data[8*i +: 8] = rom_image[rom_idx];
                end
            end
            else
            begin
                resp.fault = FAULT_UNMAPPED;
                if (cmd == CMD_READ)
                    resp.read_data = FILL_PATTERN & width_mask;
            end
        end
        return resp;
    endfunction

    // True when a read would pick up a RAM or ROM byte that holds no data yet
    function automatic bit touches_unwritten(input logic [63:0] addr, input logic [1:0] sz);
        logic [RAM_ADDR_BITS-1:0] ram_idx;
        logic [ROM_ADDR_BITS-1:0] rom_idx;
        int                       i;
        bit                       hole;
        hole = 1'b0;
        if (is_valid_card(addr[63:60]))
        begin
            for (i = 0; i < (1 << sz); i++)
            begin
                ram_idx = addr[RAM_ADDR_BITS-1:0] + i[RAM_ADDR_BITS-1:0];
                rom_idx = addr[ROM_ADDR_BITS-1:0] + i[ROM_ADDR_BITS-1:0];
                if (addr[59:56] == DEV_RAM && !ram_filled[ram_idx])
                    hole = 1'b1;
                if (addr[59:56] == DEV_ROM && !rom_filled[rom_idx])
                    hole = 1'b1;
            end
        end
        return hole;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [3:0] pick_valid_card();
        int roll;
        roll = $urandom_range(0, 2);
        if (roll == 0)
            return 4'h0;
        else if (roll == 1)
            return 4'h1;
        return 4'hF;
    endfunction

    // Offsets near both ends of a memory so that wrapping accesses come up often
    function automatic int pool_offset(input int bytes);
        if ($urandom_range(0, 1) == 1)
            return $urandom_range(0, 63);
        return bytes - 64 + $urandom_range(0, 63);
    endfunction

    task automatic send_request(
        input logic [1:0]  cmd,
        input logic [63:0] addr,
        input logic [1:0]  sz,
        input logic [63:0] wdata,
        input logic [63:0] pin
    );
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.command <= cmd;
        req_ch.address <= addr;
        req_ch.size_code <= sz;
        req_ch.write_data <= wdata;
        req_ch.port_input_value <= pin;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_responses.push_back(decode_access(cmd, addr, sz, wdata, pin));
    endtask

    task automatic test_ram_access();
        send_request(CMD_WRITE, 64'h0000_0000_0000_FFFC, SIZE_8B, 64'h0123_4567_89AB_CDEF, '0);
        send_request(CMD_READ, 64'h1012_3456_789A_FFFC, SIZE_8B, '0, '1);
        send_request(CMD_READ, 64'hF0FF_FFFF_FFFF_0001, SIZE_1B, '1, '0);
        send_request(CMD_WRITE, 64'h0000_0000_0000_0002, SIZE_2B, 64'hFFFF_FFFF_FFFF_A55A, '1);
        send_request(CMD_READ, 64'h0000_0000_0000_0000, SIZE_4B, '0, '0);
        send_request(CMD_WRITE, 64'h0000_0000_0000_FFFF, SIZE_1B, '0, '0);
    endtask

    task automatic test_rom_access();
        send_request(CMD_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, SIZE_8B, 64'hFFFF_FFFF_FFFF_FFA5, '0);
        send_request(CMD_LOAD, 64'h3A00_0000_0000_0000, SIZE_1B, 64'h0000_0000_0000_00FF, '1);
        send_request(CMD_LOAD, 64'h0000_0000_0000_0001, SIZE_2B, '0, '0);
        send_request(CMD_LOAD, 64'h1F00_0000_0000_0002, SIZE_4B, 64'h0000_0000_0000_005A, '0);
        send_request(CMD_READ, 64'hFF12_3456_789A_BFFF, SIZE_4B, '0, '0);
        send_request(CMD_READ, 64'h0F00_0000_0000_1000, SIZE_1B, '0, '0);
        // ROM has no writer
        send_request(CMD_WRITE, 64'hFF00_0000_0000_0000, SIZE_8B, '1, '0);
    endtask

    task automatic test_port_access();
        send_request(CMD_WRITE, 64'h0100_0000_0000_0008, SIZE_8B, '1, '0);
        send_request(CMD_WRITE, 64'h0100_0000_0000_000E, SIZE_2B, 64'h0000_0000_0000_1234, '0);
        send_request(CMD_WRITE, 64'h0100_0000_0000_000F, SIZE_8B, '0, '0);
        send_request(CMD_WRITE, 64'h0100_0000_0000_0000, SIZE_8B, '0, '0);
        send_request(CMD_READ, 64'h0100_0000_0000_0008, SIZE_8B, '0, '0);
        send_request(CMD_READ, 64'hF100_0000_0000_0005, SIZE_4B, '0, 64'h8877_6655_4433_2211);
        send_request(CMD_READ, 64'h0100_0000_0000_0007, SIZE_1B, '0, 64'h8000_0000_0000_0000);
    endtask

    task automatic test_fault_paths();
        send_request(CMD_READ, 64'h2000_0000_0000_0000, SIZE_8B, '0, '0);
        send_request(CMD_WRITE, 64'hE000_0000_0000_0000, SIZE_8B, '1, '0);
        send_request(CMD_READ, 64'h0200_0000_0000_0000, SIZE_1B, '0, '0);
        send_request(CMD_READ, 64'hFE00_0000_0000_0010, SIZE_4B, '0, '0);
        send_request(CMD_UNUSED, 64'h0000_0000_0000_0008, SIZE_8B, '1, '1);
    endtask

    task automatic test_random_traffic(input int count);
        logic [1:0]  cmd;
        logic [63:0] addr;
        logic [1:0]  sz;
        logic [63:0] wdata;
        logic [63:0] pin;
        int          roll;
        int          n;
        for (n = 0; n < count; n++)
        begin
            // every so often run a block of back-to-back requests
            if (n % 50 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            addr = {$urandom, $urandom};
            wdata = {$urandom, $urandom};
            pin = {$urandom, $urandom};
            sz = 2'($urandom_range(0, 3));
            cmd = 2'($urandom_range(0, 1));
            roll = $urandom_range(0, 99);
            if (roll < 35)
            begin
                addr[63:60] = pick_valid_card();
                addr[59:56] = DEV_RAM;
                addr[RAM_ADDR_BITS-1:0] = RAM_ADDR_BITS'(pool_offset(RAM_BYTES));
            end
            else if (roll < 50)
            begin
                cmd = CMD_LOAD;
                if ($urandom_range(0, 4) != 0)
                    addr[ROM_ADDR_BITS-1:0] = ROM_ADDR_BITS'(pool_offset(ROM_BYTES));
            end
            else if (roll < 65)
            begin
                cmd = CMD_READ;
                addr[63:60] = pick_valid_card();
                addr[59:56] = DEV_ROM;
                addr[ROM_ADDR_BITS-1:0] = ROM_ADDR_BITS'(pool_offset(ROM_BYTES));
            end
            else if (roll < 82)
            begin
                addr[63:60] = pick_valid_card();
                addr[59:56] = DEV_PORT;
            end
            else if (roll < 94)
            begin
                roll = $urandom_range(0, 2);
                if (roll == 0)
                    addr[63:60] = 4'($urandom_range(2, 14));
                else
                begin
                    addr[63:60] = pick_valid_card();
                    addr[59:56] = (roll == 1) ? 4'($urandom_range(2, 14)) : DEV_ROM;
                    if (roll == 2)
                        cmd = CMD_WRITE;
                end
            end
            else if (roll < 97)
                cmd = CMD_UNUSED;
            else
                cmd = 2'($urandom_range(0, 3));
            // turn a read of empty memory into a fill of the same place
            if (cmd == CMD_READ && touches_unwritten(addr, sz))
                cmd = (addr[59:56] == DEV_ROM) ? CMD_LOAD : CMD_WRITE;
            send_request(cmd, addr, sz, wdata, pin);
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin : response_pacing
        int run;
        int gap;
        rsp_ch.ready <= 1'b1;
        forever
        begin
            run = $urandom_range(1, 12);
            repeat (run) @(negedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : response_check
        bus_response_t want;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_responses.size() == 0)
            begin
                $display("%0t: unexpected response read_data=%h fault=%0d", $time,
                         rsp_ch.read_data, rsp_ch.fault);
                mismatch_count++;
            end
            else
            begin
                want = pending_responses.pop_front();
                if (rsp_ch.read_data !== want.read_data)
                begin
                    $display("%0t: read_data expected %h actual %h", $time,
                             want.read_data, rsp_ch.read_data);
                    mismatch_count++;
                end
                if (rsp_ch.fault !== want.fault)
                begin
                    $display("%0t: fault expected %0d actual %0d", $time,
                             want.fault, rsp_ch.fault);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no request or response moved for %0d cycles", $time, STALL_LIMIT);
        $display("system_bus_decoder_with_ram_rom test failed");
        $finish;
    end

    initial
    begin : main_sequence
        mismatch_count = 0;
        no_gaps = 1'b0;
        port_out_image = '0;
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.command <= CMD_READ;
        req_ch.address <= '0;
        req_ch.size_code <= SIZE_1B;
        req_ch.write_data <= '0;
        req_ch.port_input_value <= '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_ram_access();
        test_rom_access();
        test_port_access();
        test_fault_paths();
        test_random_traffic(RANDOM_ITEMS);

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("system_bus_decoder_with_ram_rom test passed");
        else
            $display("system_bus_decoder_with_ram_rom test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sbd_pkg.sv
rtl/sbd_if.sv
rtl/sbd_front.sv
rtl/sbd_queue.sv
rtl/sbd_back.sv
rtl/system_bus_decoder_with_ram_rom.sv
tb/sv/system_bus_decoder_with_ram_rom_tb.sv
